>>> rtl/core/dsf_pkg.sv
// Package for the DSF oscillator: widths, register indexes, divider status
// type, and the sine/cosine constant tables built at elaboration.
// No dependencies.
package dsf_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int TABLE_BITS  = $clog2(TABLE_DEPTH);

   localparam int DIV_STEPS   = 47;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [1:0] CSR_NOTE_STEP  = 2'd0;
   localparam logic [1:0] CSR_MOD_STEP   = 2'd1;
   localparam logic [1:0] CSR_HALF_RANGE = 2'd2;
   localparam logic [1:0] CSR_A_LIMIT    = 2'd3;

   localparam logic signed [31:0] Q15_ONE = 32'sd32768;
   localparam logic signed [31:0] TWO_Q15 = 32'sd65536;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam int SIN_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};
   localparam int COS_DIV [7] = '{2, 12, 30, 56, 90, 132, 182};

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef logic signed [16:0] table_type [TABLE_DEPTH];

   // first quadrant, Q30 Taylor series, truncated to Q15
   function automatic logic signed [16:0] quarter_q15(int unsigned r, bit want_cos);
      logic [63:0]        y;
      logic [63:0]        y2;
      logic [63:0]        term;
      logic [63:0]        prod;
      logic signed [63:0] sum;
      y    = (HALF_PI_Q30 * 64'(r)) / TABLE_DEPTH;
      y2   = (y * y) >> 30;
      term = want_cos ? (64'd1 << 30) : y;
      sum  = $signed(term);
      for (int n = 0; n < 7; n++) begin
         prod = (term * y2) >> 30;
         term = want_cos ? prod / COS_DIV[n] : prod / SIN_DIV[n];
         if (n[0]) begin
            sum = sum + $signed(term);
         end else begin
            sum = sum - $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      sum = sum >>> 15;
      if (sum > 64'sd32768) begin
         sum = 64'sd32768;
      end
      return sum[16:0];
   endfunction

   function automatic table_type build_table(bit cos_table);
      table_type          t;
      int unsigned        q;
      int unsigned        r;
      logic signed [16:0] s;
      logic signed [16:0] c;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         q = (4 * i) / TABLE_DEPTH;
         r = 4 * i - q * TABLE_DEPTH;
         s = quarter_q15(r, 1'b0);
         c = quarter_q15(r, 1'b1);
         case (q[1:0])
            2'd0: begin
               t[i] = cos_table ? c : s;
            end
            2'd1: begin
               t[i] = cos_table ? -s : c;
            end
            2'd2: begin
               t[i] = cos_table ? -c : -s;
            end
            default: begin
               t[i] = cos_table ? s : -c;
            end
         endcase
      end
      return t;
   endfunction

   localparam table_type SINE_TABLE   = build_table(1'b0);
   localparam table_type COSINE_TABLE = build_table(1'b1);

   function automatic logic [TABLE_BITS-1:0] table_index(logic [31:0] phase);
      logic [63:0] prod;
      prod = 64'(phase) * 64'(TABLE_DEPTH);
      return prod[32 +: TABLE_BITS];
   endfunction

endpackage

>>> rtl/core/dsf_mul.sv
// Shared 32x32 signed multiplier with registered product and Q15 floor shift.
// Depends on nothing.
module dsf_mul (
   input  logic               clock,
   input  logic signed [31:0] op_a,
   input  logic signed [31:0] op_b,
   output logic signed [31:0] q15_out
);

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;

   assign prod_in = 64'(op_a) * 64'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // arithmetic >>15 then keep 32 bits
   assign q15_out = prod_ff[46:15];

endmodule

>>> rtl/core/dsf_div.sv
// Restoring serial divider: (num << 15) / den, truncating, one bit a cycle.
// Zero divisor saturates. Depends on dsf_pkg.
module dsf_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [31:0]      num,
   input  logic signed [31:0]      den,
   output dsf_pkg::div_status_type sts,
   output logic signed [31:0]      quo
);
   import dsf_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [46:0]          dvd_ff, dvd_in;
   logic [31:0]          rem_ff, rem_in;
   logic [31:0]          dvs_ff, dvs_in;
   logic                 neg_ff, neg_in;
   logic signed [31:0]   quo_ff, quo_in;

   logic [31:0] num_mag;
   logic [31:0] den_mag;
   logic [32:0] rem_shift;
   logic        q_bit;
   logic [46:0] dvd_step;

   assign num_mag   = num[31] ? 32'(-num) : 32'(num);
   assign den_mag   = den[31] ? 32'(-den) : 32'(den);
   assign rem_shift = {rem_ff, dvd_ff[46]};
   assign q_bit     = (rem_shift >= {1'b0, dvs_ff});
   assign dvd_step  = {dvd_ff[45:0], q_bit};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      if (start) begin
         if (den == 32'sd0) begin
            done_in = 1'b1;
            quo_in  = num[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         end else begin
            busy_in = 1'b1;
            cnt_in  = DIV_CNT_W'(DIV_STEPS - 1);
            dvd_in  = {num_mag, 15'd0};
            rem_in  = 32'd0;
            dvs_in  = den_mag;
            neg_in  = num[31] ^ den[31];
         end
      end else if (busy_ff) begin
         dvd_in = dvd_step;
         rem_in = q_bit ? 32'(rem_shift - {1'b0, dvs_ff}) : rem_shift[31:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quo_in  = neg_ff ? -$signed(dvd_step[31:0]) : $signed(dvd_step[31:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quo      = quo_ff;

endmodule

>>> rtl/core/dsf_oscillator_sample.sv
// Discrete-summation-formula oscillator, one DAC code per input beat.
// Depends on dsf_pkg, dsf_mul and dsf_div.
//
// Each accepted beat runs through a 10-state sequencer: five products go
// through one shared registered multiplier, and a restoring divider
// resolves one quotient bit per cycle; a zero divisor skips the bit loop.
// req_stall stays high for the whole computation. The result sits in an
// output register, so the next beat is accepted while it waits. Tables are
// constant logic; no clearing pass after reset.
module dsf_oscillator_sample (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [16:0] req_shape_a,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_dac_code,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import dsf_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_LOOK  = 10'b00_0000_0010,
      ST_MUL1  = 10'b00_0000_0100,
      ST_MUL2  = 10'b00_0000_1000,
      ST_MUL3  = 10'b00_0001_0000,
      ST_MUL4  = 10'b00_0010_0000,
      ST_DIV   = 10'b00_0100_0000,
      ST_SCALE = 10'b00_1000_0000,
      ST_FIN   = 10'b01_0000_0000,
      ST_HOLD  = 10'b10_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [31:0]        note_step_ff, note_step_in;
   logic [31:0]        mod_step_ff, mod_step_in;
   logic [30:0]        half_range_ff, half_range_in;
   logic [14:0]        a_limit_ff, a_limit_in;
   logic [31:0]        note_phase_ff, note_phase_in;
   logic [31:0]        mod_phase_ff, mod_phase_in;
   logic [14:0]        a_ff, a_in;
   logic signed [16:0] sin_ff, sin_in;
   logic signed [16:0] cos_ff, cos_in;
   logic signed [31:0] asq_ff, asq_in;
   logic signed [31:0] num_ff, num_in;
   logic signed [31:0] dac_ff, dac_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_dac_ff, rsp_dac_in;

   logic               accept;
   logic               out_free;
   logic signed [31:0] op_a;
   logic signed [31:0] op_b;
   logic signed [31:0] mul_q;
   logic               div_start;
   logic signed [31:0] den;
   logic signed [31:0] quo;
   logic signed [31:0] hr;
   div_status_type     div_sts;

   dsf_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .q15_out (mul_q)
   );

   dsf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den),
      .sts   (div_sts),
      .quo   (quo)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign hr        = $signed({1'b0, half_range_ff});
   assign den       = (Q15_ONE + asq_ff) - mul_q;
   assign div_start = (state_ff == ST_MUL4);

   always_comb begin
      op_a = 32'sd0;
      op_b = 32'sd0;
      case (state_ff)
         ST_LOOK: begin
            op_a = $signed({17'd0, a_ff});
            op_b = $signed({17'd0, a_ff});
         end
         ST_MUL1: begin
            op_a = Q15_ONE - mul_q;
            op_b = 32'(sin_ff);
         end
         ST_MUL2: begin
            op_a = TWO_Q15;
            op_b = $signed({17'd0, a_ff});
         end
         ST_MUL3: begin
            op_a = mul_q;
            op_b = 32'(cos_ff);
         end
         ST_SCALE: begin
            op_a = quo;
            op_b = hr;
         end
         default: begin
            op_a = 32'sd0;
            op_b = 32'sd0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      note_step_in  = note_step_ff;
      mod_step_in   = mod_step_ff;
      half_range_in = half_range_ff;
      a_limit_in    = a_limit_ff;
      note_phase_in = note_phase_ff;
      mod_phase_in  = mod_phase_ff;
      a_in          = a_ff;
      sin_in        = sin_ff;
      cos_in        = cos_ff;
      asq_in        = asq_ff;
      num_in        = num_ff;
      dac_in        = dac_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_dac_in    = rsp_dac_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_NOTE_STEP:  note_step_in  = csr_data;
            CSR_MOD_STEP:   mod_step_in   = csr_data;
            CSR_HALF_RANGE: half_range_in = csr_data[30:0];
            CSR_A_LIMIT:    a_limit_in    = csr_data[14:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_shape_a > $signed({2'b00, a_limit_ff})) begin
                  a_in = a_limit_ff;
               end else if (req_shape_a < 17'sd0) begin
                  a_in = 15'd0;
               end else begin
                  a_in = req_shape_a[14:0];
               end
               if (req_restart) begin
                  note_phase_in = 32'd0;
                  mod_phase_in  = 32'd0;
               end
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            sin_in        = SINE_TABLE[table_index(note_phase_ff)];
            cos_in        = COSINE_TABLE[table_index(mod_phase_ff)];
            note_phase_in = note_phase_ff + note_step_ff;
            mod_phase_in  = mod_phase_ff + mod_step_ff;
            state_in      = ST_MUL1;
         end
         ST_MUL1: begin
            asq_in   = mul_q;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            num_in   = mul_q;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            state_in = ST_MUL4;
         end
         ST_MUL4: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_sts.done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            dac_in   = mul_q + hr;
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dac_in   = dac_ff[30:15];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         note_step_ff  <= 32'd0;
         mod_step_ff   <= 32'd0;
         half_range_ff <= 31'd67092480;
         a_limit_ff    <= 15'd32767;
         note_phase_ff <= 32'd0;
         mod_phase_ff  <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         note_step_ff  <= note_step_in;
         mod_step_ff   <= mod_step_in;
         half_range_ff <= half_range_in;
         a_limit_ff    <= a_limit_in;
         note_phase_ff <= note_phase_in;
         mod_phase_ff  <= mod_phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      a_ff       <= a_in;
      sin_ff     <= sin_in;
      cos_ff     <= cos_in;
      asq_ff     <= asq_in;
      num_ff     <= num_in;
      dac_ff     <= dac_in;
      rsp_dac_ff <= rsp_dac_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_dac_code = rsp_dac_ff;

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (accept && !reset) |=> req_stall)
      else $error("block not busy after accepted beat");

   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      (div_sts.busy || div_sts.done) |-> (state_ff == ST_DIV))
      else $error("divider active outside divide state");

   a_rsp_from_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall)) |-> $past(state_ff == ST_HOLD))
      else $error("result beat loaded outside hold state");
`endif

endmodule
